>>> hw/rtl/tcc_pkg.sv
// Shared types and constants of the text console cursor engine.
// Holds the request and result structs, the result kinds and character codes.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tcc_pkg;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KindWrite  = 2'd0,
    KindScroll = 2'd1,
    KindClear  = 2'd2,
    KindCursor = 2'd3
  } kind_e;

  // Request commands.
  localparam logic CmdPut   = 1'b0;
  localparam logic CmdClear = 1'b1;

  // Character codes with a special meaning.
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] BlankChar     = 8'h20;
  localparam logic [7:0] PrintLimit    = 8'h80;

  // Attribute after reset: white on black.
  localparam logic [7:0] AttrReset = 8'h0F;

  // Tab stops fall on multiples of eight.
  localparam int unsigned TabStep = 8;
  localparam int unsigned TabMask = TabStep - 1;

  // Width of the cell index on the result port.
  localparam int unsigned CellIdxW = 11;

  // One request.
  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } item_t;

  // One result word.
  typedef struct packed {
    kind_e                 kind;
    logic [CellIdxW-1:0]   cell_index;
    logic [15:0]           cell_word;
    logic                  last;
  } result_t;

  // The results that one request causes, packed from slot 0 upwards.
  typedef struct packed {
    result_t [2:0] res;
    logic    [1:0] count;
  } res_set_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcc_step.sv
// Cursor step logic: resolves one request against the current cursor.
// Produces the packed result set and the next cursor. Uses tcc_pkg.
`default_nettype none

module tcc_step #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  tcc_pkg::item_t                 item_i,
  input  logic [7:0]                     attr_i,
  input  logic [$clog2(COLUMNS)-1:0]     col_i,
  input  logic [$clog2(ROWS)-1:0]        row_i,
  output logic [$clog2(COLUMNS)-1:0]     col_o,
  output logic [$clog2(ROWS)-1:0]        row_o,
  output tcc_pkg::res_set_t              set_o
);

  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned WColW = $clog2(COLUMNS + tcc_pkg::TabStep);
  localparam int unsigned WRowW = $clog2(ROWS + 1);
  localparam int unsigned IdxW  = $clog2(COLUMNS * ROWS);

  logic [WColW-1:0] col_w;
  logic [WRowW-1:0] row_w;
  logic [ColW-1:0]  wr_col;
  logic             wr_en;
  logic [15:0]      wr_word;
  logic             scroll;
  logic [15:0]      blank;
  logic [IdxW-1:0]  wr_idx;
  logic [IdxW-1:0]  cur_idx;
  logic [1:0]       n;

  assign blank = {attr_i, tcc_pkg::BlankChar};

  // Cursor movement for a put request.
  always_comb begin
    col_w   = WColW'(col_i);
    row_w   = WRowW'(row_i);
    wr_col  = col_i;
    wr_en   = 1'b0;
    wr_word = blank;
    case (item_i.char_code)
      tcc_pkg::CharBackspace: begin
        if (col_i != '0) begin
          col_w  = col_w - WColW'(1);
          wr_col = col_i - ColW'(1);
          wr_en  = 1'b1;
        end
      end
      tcc_pkg::CharTab: begin
        col_w = (col_w + WColW'(tcc_pkg::TabStep)) & ~WColW'(tcc_pkg::TabMask);
      end
      tcc_pkg::CharReturn: begin
        col_w = '0;
      end
      tcc_pkg::CharNewline: begin
        col_w = '0;
        row_w = row_w + WRowW'(1);
      end
      default: begin
        if (item_i.char_code >= tcc_pkg::BlankChar &&
            item_i.char_code < tcc_pkg::PrintLimit) begin
          wr_en   = 1'b1;
          wr_word = {attr_i, item_i.char_code};
          col_w   = col_w + WColW'(1);
        end
      end
    endcase

    // Wrap at the right edge.
    if (col_w >= WColW'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + WRowW'(1);
    end

    // Scroll when the cursor runs off the bottom.
    scroll = (row_w >= WRowW'(ROWS));
    if (scroll) begin
      row_w = WRowW'(ROWS - 1);
    end
  end

  // Linear cell indices of the written cell and of the final cursor.
  assign wr_idx  = IdxW'(row_i) * IdxW'(COLUMNS) + IdxW'(wr_col);
  assign cur_idx = IdxW'(row_w) * IdxW'(COLUMNS) + IdxW'(col_w);

  // Pack the results in order and pick the next cursor.
  always_comb begin
    set_o = '0;
    n     = '0;
    if (item_i.cmd == tcc_pkg::CmdClear) begin
      set_o.res[0].kind      = tcc_pkg::KindClear;
      set_o.res[0].cell_word = blank;
      set_o.res[1].kind      = tcc_pkg::KindCursor;
      set_o.res[1].last      = 1'b1;
      set_o.count            = 2'd2;
      col_o                  = '0;
      row_o                  = '0;
    end else begin
      if (wr_en) begin
        set_o.res[n].kind       = tcc_pkg::KindWrite;
        set_o.res[n].cell_index = tcc_pkg::CellIdxW'(wr_idx);
        set_o.res[n].cell_word  = wr_word;
        n                       = n + 2'd1;
      end
      if (scroll) begin
        set_o.res[n].kind      = tcc_pkg::KindScroll;
        set_o.res[n].cell_word = blank;
        n                      = n + 2'd1;
      end
      set_o.res[n].kind       = tcc_pkg::KindCursor;
      set_o.res[n].cell_index = tcc_pkg::CellIdxW'(cur_idx);
      set_o.res[n].last       = 1'b1;
      set_o.count             = n + 2'd1;
      col_o                   = col_w[ColW-1:0];
      row_o                   = row_w[RowW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcc_result_buf.sv
// Result register of the console engine: holds one request's result set.
// Results leave front first, one per cycle unless stalled. Uses tcc_pkg.
`default_nettype none

module tcc_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tcc_pkg::res_set_t  set_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcc_pkg::result_t   out_data_o
);

  tcc_pkg::result_t [2:0] res_q, res_d;
  logic [2:0]             vld_q, vld_d;
  logic                   take;

  assign take        = vld_q[0] && !out_stall_i;
  assign free_o      = !vld_q[1] && (!vld_q[0] || take);
  assign out_valid_o = vld_q[0];
  assign out_data_o  = res_q[0];

  // Load a whole set, or shift the queue down when the front is taken.
  always_comb begin
    res_d = res_q;
    vld_d = vld_q;
    if (load_i) begin
      res_d = set_i.res;
      case (set_i.count)
        2'd1:    vld_d = 3'b001;
        2'd2:    vld_d = 3'b011;
        2'd3:    vld_d = 3'b111;
        default: vld_d = 3'b000;
      endcase
    end else if (take) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      vld_d    = {1'b0, vld_q[2:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: input register, cursor and
// attribute registers, step logic and result buffer. Uses tcc_pkg, tcc_step
// and tcc_result_buf.
//
//   Channel  Direction  Handshake                 Payload
//   in       request    in_valid_i / in_stall_o   tcc_pkg::item_t
//   out      result     out_valid_o / out_stall_i tcc_pkg::result_t
//   cfg      write      cfg_we_i                  cfg_wdata_i (attribute)
//
// A request is registered on acceptance and resolved combinationally into one
// to three results, which are loaded into the result buffer once it is free
// and leave it one per cycle while the result port is not stalled. With a
// free buffer the first result is offered in the cycle after the request is
// registered. Reset clears the cursor to the home cell and sets the
// attribute to white on black. A stalled result port holds the buffer; the
// input register keeps taking one request ahead while the buffer drains.
`default_nettype none

module text_console_cursor_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcc_pkg::item_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcc_pkg::result_t  out_data_o
);

  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned RowW = $clog2(ROWS);

  tcc_pkg::item_t    in_q, in_d;
  logic              in_vld_q, in_vld_d;
  logic [7:0]        attr_q, attr_d;
  logic [ColW-1:0]   col_q, col_d, col_next;
  logic [RowW-1:0]   row_q, row_d, row_next;
  tcc_pkg::res_set_t set;
  logic              free;
  logic              load;
  logic              in_take;

  // Input register handshake.
  assign load       = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_d     = in_take ? in_data_i : in_q;
    in_vld_d = in_take ? 1'b1 : (load ? 1'b0 : in_vld_q);
    attr_d   = cfg_we_i ? cfg_wdata_i : attr_q;
    col_d    = load ? col_next : col_q;
    row_d    = load ? row_next : row_q;
  end

  // Resolve the registered request against the cursor.
  tcc_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .item_i (in_q),
    .attr_i (attr_q),
    .col_i  (col_q),
    .row_i  (row_q),
    .col_o  (col_next),
    .row_o  (row_next),
    .set_o  (set)
  );

  // Result buffer towards the output port.
  tcc_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .set_i       (set),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Control state and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      attr_q   <= tcc_pkg::AttrReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      attr_q   <= attr_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Request payload.
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // The cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ColW'(COLUMNS - 1) >= col_q) && (RowW'(ROWS - 1) >= row_q))
    else $error("cursor left the screen");

  // A cursor update is always the final result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == tcc_pkg::KindCursor) == out_data_o.last))
    else $error("last flag does not match cursor update");

  // A loaded set appears on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded result set not presented");

  // The input side only stalls while a request waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("stall without a held request");

endmodule

`default_nettype wire
